FILE: hdl/dmcl_pkg.sv
// Shared constants and controller/datapath interface types for the
// direct-mapped cache tag lookup. No dependencies.
package dmcl_pkg;

  // Fixed field widths of the word on each channel
  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 5;
  localparam int BLOCK_W  = 27;
  localparam int LINE_W   = 7;
  localparam int TAG_W    = 20;
  localparam int COUNT_W  = 32;

  // Default geometry
  localparam int NUM_LINES_DEF   = 128;
  localparam int OFFSET_BITS_DEF = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;   // write one invalid line of the clearing sweep
    logic rd_en;    // take the input word and read its line
    logic commit;   // resolve lookup, update line and counters, load result
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last; // sweep is at the last line
    logic out_busy; // result register full and not taken this cycle
  } ctl_sts_t;

endpackage

FILE: hdl/dmcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dmcl_ctrl.sv
// Sequencing controller: reset clearing sweep, accept, lookup/commit.
// Depends on dmcl_pkg.
module dmcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmcl_pkg::ctl_sts_t sts_i,
  output dmcl_pkg::ctl_cmd_t cmd_o
);
  import dmcl_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // wait here while the previous result is still unclaimed
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: hdl/dmcl_dpath.sv
// Datapath: address split, line store (valid bit plus tag in RAM), hit/miss
// resolution, saturating counters and result register.
// Depends on dmcl_pkg and dmcl_ram.
module dmcl_dpath #(
  parameter int NUM_LINES   = dmcl_pkg::NUM_LINES_DEF,
  parameter int OFFSET_BITS = dmcl_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dmcl_pkg::ctl_cmd_t             cmd_i,
  output dmcl_pkg::ctl_sts_t             sts_o,
  input  logic [dmcl_pkg::ADDR_W-1:0]    address_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [dmcl_pkg::OFFSET_W-1:0]  byte_offset_o,
  output logic [dmcl_pkg::BLOCK_W-1:0]   block_number_o,
  output logic [dmcl_pkg::LINE_W-1:0]    line_index_o,
  output logic [dmcl_pkg::TAG_W-1:0]     tag_value_o,
  output logic                           is_miss_o,
  output logic                           replaced_o,
  output logic [dmcl_pkg::TAG_W-1:0]     evicted_tag_o,
  output logic [dmcl_pkg::COUNT_W-1:0]   hits_so_far_o,
  output logic [dmcl_pkg::COUNT_W-1:0]   misses_so_far_o
);
  import dmcl_pkg::*;

  localparam int LINE_BITS = $clog2(NUM_LINES);
  localparam int TAG_BITS  = ADDR_W - OFFSET_BITS - LINE_BITS;
  localparam int ENTRY_W   = TAG_BITS + 1;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [LINE_BITS-1:0] LAST_LINE = LINE_BITS'(NUM_LINES - 1);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  logic [ADDR_W-1:0]    addr_q;
  logic [LINE_BITS-1:0] clr_q;
  logic [COUNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [COUNT_W-1:0]   miss_cnt_q, miss_cnt_d;
  logic                 out_valid_q;

  logic [LINE_BITS-1:0] line_in, line_cur;
  logic [TAG_BITS-1:0]  tag_cur, stored_tag;
  logic                 stored_vld, hit, repl;
  logic [ENTRY_W-1:0]   rd_entry, wr_entry;
  logic [LINE_BITS-1:0] wr_line;
  logic                 wr_en;

  // Address split of the incoming and the held word
  assign line_in  = address_i[OFFSET_BITS +: LINE_BITS];
  assign line_cur = addr_q[OFFSET_BITS +: LINE_BITS];
  assign tag_cur  = addr_q[ADDR_W-1 -: TAG_BITS];

  // Line store port mux: clearing sweep writes invalid entries
  assign wr_en    = cmd_i.clr_en | cmd_i.commit;
  assign wr_line  = cmd_i.clr_en ? clr_q : line_cur;
  assign wr_entry = cmd_i.clr_en ? '0 : {1'b1, tag_cur};

  dmcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_line),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (line_in),
    .rdata_o (rd_entry)
  );

  // Lookup resolution
  assign stored_vld = rd_entry[TAG_BITS];
  assign stored_tag = rd_entry[TAG_BITS-1:0];
  assign hit        = stored_vld && (stored_tag == tag_cur);
  assign repl       = stored_vld && !hit;

  assign hit_cnt_d  = hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
  assign miss_cnt_d = hit ? miss_cnt_q : sat_inc(miss_cnt_q);

  // Control registers: sweep index, counters, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) clr_q <= clr_q + LINE_BITS'(1);
      if (cmd_i.commit) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [ADDR_W-1:0] off_ext, blk_ext, line_ext, tag_ext, evict_ext;
  logic [ADDR_W-1:0] off_q, blk_q, line_q, tag_q, evict_q;
  logic              miss_q, repl_q;

  assign off_ext   = addr_q & OFF_MASK;
  assign blk_ext   = addr_q >> OFFSET_BITS;
  assign line_ext  = ADDR_W'(line_cur);
  assign tag_ext   = ADDR_W'(tag_cur);
  assign evict_ext = repl ? ADDR_W'(stored_tag) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) addr_q <= address_i;
    if (cmd_i.commit) begin
      off_q   <= off_ext;
      blk_q   <= blk_ext;
      line_q  <= line_ext;
      tag_q   <= tag_ext;
      evict_q <= evict_ext;
      miss_q  <= !hit;
      repl_q  <= repl;
    end
  end

  assign sts_o.clr_last = (clr_q == LAST_LINE);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign byte_offset_o   = off_q[OFFSET_W-1:0];
  assign block_number_o  = blk_q[BLOCK_W-1:0];
  assign line_index_o    = line_q[LINE_W-1:0];
  assign tag_value_o     = tag_q[TAG_W-1:0];
  assign is_miss_o       = miss_q;
  assign replaced_o      = repl_q;
  assign evicted_tag_o   = evict_q[TAG_W-1:0];
  // counters change only on commit, which waits for the result register
  assign hits_so_far_o   = hit_cnt_q;
  assign misses_so_far_o = miss_cnt_q;

endmodule

FILE: hdl/direct_mapped_cache_lookup_top.sv
// Channel  | handshake              | word
// ---------+------------------------+---------------------------------------
// in       | in_valid_i/in_ready_o  | address_i
// out      | out_valid_o/out_ready_i| offset, block, line, tag, miss, repl,
//          |                        | evicted tag, hit and miss counts
//
// Each word passes two steps: accept plus line store read, then compare and
// write back; this RAM read-then-write on one line store holds off the next
// accept until the write back. After reset a clearing sweep writes every line
// invalid, with in_ready_o low. A result waiting in the output register does
// not block the next accept; its lookup then waits until the result is taken.
// Top level; depends on dmcl_pkg, dmcl_ctrl, dmcl_dpath, dmcl_ram.
module direct_mapped_cache_lookup_top #(
  parameter int NUM_LINES   = dmcl_pkg::NUM_LINES_DEF,
  parameter int OFFSET_BITS = dmcl_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dmcl_pkg::ADDR_W-1:0]    address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dmcl_pkg::OFFSET_W-1:0]  byte_offset_o,
  output logic [dmcl_pkg::BLOCK_W-1:0]   block_number_o,
  output logic [dmcl_pkg::LINE_W-1:0]    line_index_o,
  output logic [dmcl_pkg::TAG_W-1:0]     tag_value_o,
  output logic                           is_miss_o,
  output logic                           replaced_o,
  output logic [dmcl_pkg::TAG_W-1:0]     evicted_tag_o,
  output logic [dmcl_pkg::COUNT_W-1:0]   hits_so_far_o,
  output logic [dmcl_pkg::COUNT_W-1:0]   misses_so_far_o
);
  import dmcl_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  dmcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dmcl_dpath #(
    .NUM_LINES   (NUM_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .address_i       (address_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .byte_offset_o   (byte_offset_o),
    .block_number_o  (block_number_o),
    .line_index_o    (line_index_o),
    .tag_value_o     (tag_value_o),
    .is_miss_o       (is_miss_o),
    .replaced_o      (replaced_o),
    .evicted_tag_o   (evicted_tag_o),
    .hits_so_far_o   (hits_so_far_o),
    .misses_so_far_o (misses_so_far_o)
  );

endmodule

FILE: hdl/dmcl_checker.sv
// Port-level checks for the cache tag lookup, bound to the top level.
// Depends on dmcl_pkg and direct_mapped_cache_lookup_top.
module dmcl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           is_miss_o,
  input logic                           replaced_o,
  input logic [dmcl_pkg::TAG_W-1:0]     evicted_tag_o,
  input logic [dmcl_pkg::COUNT_W-1:0]   hits_so_far_o,
  input logic [dmcl_pkg::COUNT_W-1:0]   misses_so_far_o
);
  import dmcl_pkg::*;

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // an unclaimed result holds, counters included
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hits_so_far_o)
      && $stable(misses_so_far_o) && $stable(is_miss_o))
    else $error("result changed while stalled");

  // a hit never evicts and is counted
  a_hit_no_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_miss_o |-> !replaced_o && hits_so_far_o != '0)
    else $error("hit reported a replacement or zero hit count");

  // evicted tag is zero unless a line was replaced
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !replaced_o |-> evicted_tag_o == '0)
    else $error("evicted tag nonzero without replacement");

  // a miss is counted
  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_miss_o |-> misses_so_far_o != '0)
    else $error("miss reported with zero miss count");

endmodule

bind direct_mapped_cache_lookup_top dmcl_checker u_dmcl_checker (.*);

FILE: tb/direct_mapped_cache_lookup_top_tb.sv
`timescale 1ns / 100ps
// Testbench for direct_mapped_cache_lookup_top: directed and random address
// streams, every result word checked against a hand-written result or
// a behavioral tag-store model. Depends on dmcl_pkg and the RTL top level.
module direct_mapped_cache_lookup_top_tb;
  import dmcl_pkg::*;

  localparam int NLINES     = NUM_LINES_DEF;
  localparam int OBITS      = OFFSET_BITS_DEF;
  localparam int RAND_WORDS = 1400;
  localparam int CALM_WORDS = 150;
  localparam int N_DIR      = 22;

  // One result word, field for field as the output channel carries it
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [BLOCK_W-1:0]  block;
    logic [LINE_W-1:0]   line;
    logic [TAG_W-1:0]    tag;
    logic                miss;
    logic                repl;
    logic [TAG_W-1:0]    evicted;
    logic [COUNT_W-1:0]  hits;
    logic [COUNT_W-1:0]  misses;
  } lookup_res_t;

  // Directed row: address, whether the result is written out by hand, result
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              typed;
    lookup_res_t       res;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [ADDR_W-1:0]   address_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OFFSET_W-1:0] byte_offset_o;
  logic [BLOCK_W-1:0]  block_number_o;
  logic [LINE_W-1:0]   line_index_o;
  logic [TAG_W-1:0]    tag_value_o;
  logic                is_miss_o;
  logic                replaced_o;
  logic [TAG_W-1:0]    evicted_tag_o;
  logic [COUNT_W-1:0]  hits_so_far_o;
  logic [COUNT_W-1:0]  misses_so_far_o;

  // Model copy of the cache state
  logic [ADDR_W-1:0]  model_tag [NLINES];
  logic               model_valid [NLINES];
  logic [COUNT_W-1:0] model_hits;
  logic [COUNT_W-1:0] model_misses;

  lookup_res_t pending_lookups[$];
  int          mismatches  = 0;
  int          n_checked   = 0;
  int          n_hits      = 0;
  int          n_fills     = 0;
  int          n_evicts    = 0;
  bit          calm        = 1'b0;
  int          rx_stall    = 0;
  int          rx_pct      = 0;
  int          rx_span     = 0;

  direct_mapped_cache_lookup_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_offset_o   (byte_offset_o),
    .block_number_o  (block_number_o),
    .line_index_o    (line_index_o),
    .tag_value_o     (tag_value_o),
    .is_miss_o       (is_miss_o),
    .replaced_o      (replaced_o),
    .evicted_tag_o   (evicted_tag_o),
    .hits_so_far_o   (hits_so_far_o),
    .misses_so_far_o (misses_so_far_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Look up one address in the model cache, update it, return the result word
  function automatic lookup_res_t cache_lookup(input logic [ADDR_W-1:0] a);
    lookup_res_t       r;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] tg;
    int unsigned       ln;
    blk = a >> OBITS;
    ln  = blk % NLINES;
    tg  = blk / NLINES;
    r = '0;
    r.offset = OFFSET_W'(a % (32'd1 << OBITS));
    r.block  = BLOCK_W'(blk);
    r.line   = LINE_W'(ln);
    r.tag    = TAG_W'(tg);
    if (model_valid[ln] && model_tag[ln] == tg) begin
      if (model_hits != COUNT_MAX) model_hits++;
    end else begin
      r.miss = 1'b1;
      if (model_valid[ln]) begin
        r.repl    = 1'b1;
        r.evicted = TAG_W'(model_tag[ln]);
      end
      model_tag[ln]   = tg;
      model_valid[ln] = 1'b1;
      if (model_misses != COUNT_MAX) model_misses++;
    end
    r.hits   = model_hits;
    r.misses = model_misses;
    return r;
  endfunction

  // Drop valid for an idle burst set by n, with junk on the address lines
  task automatic idle_burst(input int n);
    in_valid_i <= 1'b0;
    address_i  <= $urandom;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one address word, hold it until taken, then queue its result
  task automatic send_word(input logic [ADDR_W-1:0] a, input logic typed,
                           input lookup_res_t hand_res);
    lookup_res_t pred;
    in_valid_i <= 1'b1;
    address_i  <= a;
    do @(posedge clk_i); while (!in_ready_o);
    pred = cache_lookup(a);
    pending_lookups.push_back(typed ? hand_res : pred);
  endtask

  // Stimulus
  initial begin
    dir_row_t          rows [N_DIR];
    logic [ADDR_W-1:0] recent [16];
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] prev_a;
    int                idle_pct;
    int                slot;

    for (int i = 0; i < NLINES; i++) begin
      model_tag[i]   = '0;
      model_valid[i] = 1'b0;
    end
    model_hits   = '0;
    model_misses = '0;
    for (int i = 0; i < 16; i++) recent[i] = $urandom;

    // Hand-written rows: cold fill, hit, top address, hits, evictions
    // including an evicted tag of zero; the rest go through the model.
    rows = '{
      '{32'h0000_0000, 1'b1, '{5'd0, 27'h0, 7'd0, 20'h0,
                               1'b1, 1'b0, 20'h0, 32'd0, 32'd1}},
      '{32'h0000_001F, 1'b1, '{5'd31, 27'h0, 7'd0, 20'h0,
                               1'b0, 1'b0, 20'h0, 32'd1, 32'd1}},
      '{32'hFFFF_FFFF, 1'b1, '{5'd31, 27'h7FF_FFFF, 7'd127, 20'hFFFFF,
                               1'b1, 1'b0, 20'h0, 32'd1, 32'd2}},
      '{32'hFFFF_FFE0, 1'b1, '{5'd0, 27'h7FF_FFFF, 7'd127, 20'hFFFFF,
                               1'b0, 1'b0, 20'h0, 32'd2, 32'd2}},
      '{32'h0000_0FE0, 1'b1, '{5'd0, 27'h7F, 7'd127, 20'h0,
                               1'b1, 1'b1, 20'hFFFFF, 32'd2, 32'd3}},
      '{32'hFFFF_F000, 1'b1, '{5'd0, 27'h7FF_FF80, 7'd0, 20'hFFFFF,
                               1'b1, 1'b1, 20'h0, 32'd2, 32'd4}},
      '{32'h0000_0000, 1'b1, '{5'd0, 27'h0, 7'd0, 20'h0,
                               1'b1, 1'b1, 20'hFFFFF, 32'd2, 32'd5}},
      '{32'h0000_0020, 1'b0, '0},
      '{32'h0000_0040, 1'b0, '0},
      '{32'h1234_5678, 1'b0, '0},
      '{32'h1234_5660, 1'b0, '0},
      '{32'h8765_4321, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h0000_1000, 1'b0, '0},
      '{32'h0000_2000, 1'b0, '0},
      '{32'h0000_1000, 1'b0, '0},
      '{32'h0000_0FFF, 1'b0, '0},
      '{32'hDEAD_BEEF, 1'b0, '0},
      '{32'hDEAD_BEE0, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    for (int i = 0; i < N_DIR; i++) begin
      if ($urandom_range(0, 99) < 20) idle_burst($urandom_range(1, 18));
      send_word(rows[i].addr, rows[i].typed, rows[i].res);
    end

    // Random part: reuse for hits, few tags on few lines for evictions,
    // sequential streams for fills, and raw addresses for bit coverage
    prev_a   = 32'hDEAD_BEE0;
    idle_pct = 0;
    for (int k = 0; k < RAND_WORDS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 5;
          2: idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      if (k >= RAND_WORDS - CALM_WORDS) calm = 1'b1;
      if (!calm && $urandom_range(0, 99) < idle_pct) idle_burst($urandom_range(1, 18));

      slot = $urandom_range(0, 99);
      if (slot < 35) begin
        a = recent[$urandom_range(0, 15)];
        a[OBITS-1:0] = OBITS'($urandom);
      end else if (slot < 65) begin
        a = $urandom;
        a[ADDR_W-1:12] = ($urandom_range(0, 1) != 0) ? 20'($urandom_range(0, 3))
                                                     : 20'hFFFFF - 20'($urandom_range(0, 1));
        a[11:OBITS] = LINE_W'($urandom_range(0, 7));
      end else if (slot < 85) begin
        a = prev_a + (32'd1 << OBITS);
      end else begin
        a = $urandom;
      end
      recent[$urandom_range(0, 15)] = a;
      prev_a = a;
      send_word(a, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d lookups checked: %0d hits, %0d cold fills, %0d evictions",
             n_checked, n_hits, n_fills, n_evicts);
    if (mismatches == 0) begin
      $display("direct_mapped_cache_lookup_top_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("direct_mapped_cache_lookup_top_tb: errors");
    end
    $finish;
  end

  // Output side: check each taken word, then pick the next ready value
  always @(posedge clk_i) begin
    lookup_res_t got;
    lookup_res_t want;
    logic        bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{byte_offset_o, block_number_o, line_index_o, tag_value_o, is_miss_o,
              replaced_o, evicted_tag_o, hits_so_far_o, misses_so_far_o};
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with no lookup pending, block %h", $realtime,
                   got.block);
      end else begin
        want = pending_lookups.pop_front();
        n_checked++;
        if (!want.miss) n_hits++;
        else if (want.repl) n_evicts++;
        else n_fills++;
        bad = (got.offset !== want.offset) || (got.block !== want.block) ||
              (got.line !== want.line) || (got.tag !== want.tag) ||
              (got.miss !== want.miss) || (got.repl !== want.repl) ||
              (got.evicted !== want.evicted) || (got.hits !== want.hits) ||
              (got.misses !== want.misses);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: exp off %h blk %h line %h tag %h miss %b repl %b ev %h hit %0d mis %0d",
                     $realtime, want.offset, want.block, want.line, want.tag, want.miss,
                     want.repl, want.evicted, want.hits, want.misses);
            $display("%0t: act off %h blk %h line %h tag %h miss %b repl %b ev %h hit %0d mis %0d",
                     $realtime, got.offset, got.block, got.line, got.tag, got.miss,
                     got.repl, got.evicted, got.hits, got.misses);
          end
        end
      end
    end

    // Stall bursts with length set by rx_stall, rate rx_pct redrawn when rx_span runs out
    if (rx_span == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pct = 0;
        1: rx_pct = 5;
        2: rx_pct = 20;
        default: rx_pct = 50;
      endcase
      rx_span = $urandom_range(50, 300);
    end else begin
      rx_span--;
    end
    if (rx_stall != 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
      rx_stall = $urandom_range(0, 17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("timeout, %0d lookups still pending", pending_lookups.size());
    $display("direct_mapped_cache_lookup_top_tb: errors");
    $finish;
  end

endmodule
